// ===== hw/rtl/power_button_shutdown_sequencer_core_assert.svh =====
// assertion macros used by power_button_shutdown_sequencer_core.sv
`ifndef POWER_BUTTON_SHUTDOWN_SEQUENCER_CORE_ASSERT_SVH
`define POWER_BUTTON_SHUTDOWN_SEQUENCER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PBSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pbss assertion failed");
`define PBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pbss assertion failed");
`else
`define PBSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/pbss_pkg.sv =====
`timescale 1ns / 1ps

package pbss_pkg;

  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_PERIODS = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_TICKS_RST   = 8'd10;
  localparam logic [CFG_W-1:0] BLINK_TICKS_RST      = 8'd11;
  localparam logic [CFG_W-1:0] SHUTDOWN_PERIODS_RST = 8'd30;

  typedef enum logic [1:0] {
    MODE_ON   = 2'd0,
    MODE_SHUT = 2'd1,
    MODE_OFF  = 2'd2
  } mode_t;

  typedef struct packed {
    logic  lamp_on;
    logic  relay_on;
    logic  shutdown_request;
    mode_t mode_now;
  } pbss_res_t;

endpackage

// ===== hw/rtl/pbss_press_qual.sv =====
`timescale 1ns / 1ps

module pbss_press_qual #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        button_down,
  input  logic [pbss_pkg::CFG_W-1:0]  debounce_ticks,
  output logic                        press
);

  localparam int CMP_W = (COUNT_WIDTH > pbss_pkg::CFG_W) ? COUNT_WIDTH : pbss_pkg::CFG_W;

  logic [COUNT_WIDTH-1:0] press_count_r;
  logic [COUNT_WIDTH-1:0] press_count_nxt;
  logic [COUNT_WIDTH-1:0] count_inc;

  always_comb begin
    if (press_count_r == {COUNT_WIDTH{1'b1}}) begin
      count_inc = press_count_r;
    end else begin
      count_inc = press_count_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end
    if (!button_down) begin
      count_inc = '0;
    end
    press = CMP_W'(count_inc) >= CMP_W'(debounce_ticks);
    press_count_nxt = press ? '0 : count_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_count_r <= '0;
    end else if (step) begin
      press_count_r <= press_count_nxt;
    end
  end

endmodule

// ===== hw/rtl/pbss_seq.sv =====
`timescale 1ns / 1ps

module pbss_seq #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        press,
  input  logic [pbss_pkg::CFG_W-1:0]  blink_ticks,
  input  logic [pbss_pkg::CFG_W-1:0]  shutdown_periods,
  output pbss_pkg::pbss_res_t         res
);

  localparam int CMP_W = (COUNT_WIDTH > pbss_pkg::CFG_W) ? COUNT_WIDTH : pbss_pkg::CFG_W;

  pbss_pkg::mode_t        mode_r;
  pbss_pkg::mode_t        mode_nxt;
  logic [COUNT_WIDTH-1:0] tick_r;
  logic [COUNT_WIDTH-1:0] tick_nxt;
  logic [COUNT_WIDTH-1:0] tick_mid;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [COUNT_WIDTH-1:0] period_r;
  logic [COUNT_WIDTH-1:0] period_nxt;
  logic [COUNT_WIDTH-1:0] period_mid;
  logic [COUNT_WIDTH-1:0] period_inc;
  logic                   phase_r;
  logic                   phase_nxt;
  logic                   period_limit;
  logic                   wrap;

  assign tick_inc = (tick_r == {COUNT_WIDTH{1'b1}}) ? tick_r
                  : tick_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign period_limit = CMP_W'(period_r) >= CMP_W'(shutdown_periods);

  // next mode
  always_comb begin
    unique case (mode_r)
      pbss_pkg::MODE_ON: begin
        mode_nxt = press ? pbss_pkg::MODE_SHUT : pbss_pkg::MODE_ON;
      end
      pbss_pkg::MODE_SHUT: begin
        if (press) begin
          mode_nxt = pbss_pkg::MODE_ON;
        end else if (period_limit) begin
          mode_nxt = pbss_pkg::MODE_OFF;
        end else begin
          mode_nxt = pbss_pkg::MODE_SHUT;
        end
      end
      default: begin
        mode_nxt = press ? pbss_pkg::MODE_ON : pbss_pkg::MODE_OFF;
      end
    endcase
  end

  // counters and blink phase
  always_comb begin
    unique case (mode_r)
      pbss_pkg::MODE_ON: begin
        tick_mid   = press ? '0 : tick_r;
        period_mid = press ? '0 : period_r;
      end
      pbss_pkg::MODE_SHUT: begin
        tick_mid   = tick_inc;
        period_mid = press ? '0 : period_r;
      end
      default: begin
        tick_mid   = tick_r;
        period_mid = period_r;
      end
    endcase
    wrap = CMP_W'(tick_mid) >= CMP_W'(blink_ticks);
    period_inc = (period_mid == {COUNT_WIDTH{1'b1}}) ? period_mid
               : period_mid + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    tick_nxt   = wrap ? '0 : tick_mid;
    period_nxt = wrap ? period_inc : period_mid;
    phase_nxt  = phase_r ^ wrap;
  end

  // outputs
  always_comb begin
    unique case (mode_r)
      pbss_pkg::MODE_ON: begin
        res.lamp_on  = 1'b1;
        res.relay_on = 1'b1;
      end
      pbss_pkg::MODE_SHUT: begin
        res.lamp_on  = phase_r;
        res.relay_on = 1'b1;
      end
      default: begin
        res.lamp_on  = 1'b0;
        res.relay_on = 1'b0;
      end
    endcase
    res.shutdown_request = (mode_nxt == pbss_pkg::MODE_SHUT);
    res.mode_now         = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pbss_pkg::MODE_ON;
      tick_r   <= '0;
      period_r <= '0;
      phase_r  <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      tick_r   <= tick_nxt;
      period_r <= period_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

// ===== hw/rtl/power_button_shutdown_sequencer_core.sv =====
// path: an input item passes through the input register and then the result
//   register before its result item can be taken
// throughput: one item per cycle when out_ready does not stall; the input register
//   and the output register let a new item be taken while a result waits on out_ready
// reset: synchronous active-low rst_n; mode on, all counters and blink phase
//   cleared, registers back to debounce 10, blink 11, shutdown periods 30
`timescale 1ns / 1ps
`include "power_button_shutdown_sequencer_core_assert.svh"

module power_button_shutdown_sequencer_core #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_button_down,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_lamp_on,
  output logic                            out_relay_on,
  output logic                            out_shutdown_request,
  output logic [1:0]                      out_mode_now,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbss_pkg::CFG_W-1:0]      cfg_data
);

  logic                       s1_valid_r;
  logic                       s1_button_r;
  logic                       adv;
  logic                       press;
  logic                       out_valid_r;
  pbss_pkg::pbss_res_t        res;
  pbss_pkg::pbss_res_t        out_res_r;
  logic [pbss_pkg::CFG_W-1:0] debounce_ticks_r;
  logic [pbss_pkg::CFG_W-1:0] blink_ticks_r;
  logic [pbss_pkg::CFG_W-1:0] shutdown_periods_r;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= pbss_pkg::DEBOUNCE_TICKS_RST;
      blink_ticks_r      <= pbss_pkg::BLINK_TICKS_RST;
      shutdown_periods_r <= pbss_pkg::SHUTDOWN_PERIODS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pbss_pkg::CFG_DEBOUNCE_TICKS:   debounce_ticks_r   <= cfg_data;
        pbss_pkg::CFG_BLINK_TICKS:      blink_ticks_r      <= cfg_data;
        pbss_pkg::CFG_SHUTDOWN_PERIODS: shutdown_periods_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_button_r <= in_button_down;
    end
  end

  pbss_press_qual #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_press_qual (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (adv),
    .button_down    (s1_button_r),
    .debounce_ticks (debounce_ticks_r),
    .press          (press)
  );

  pbss_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (adv),
    .press            (press),
    .blink_ticks      (blink_ticks_r),
    .shutdown_periods (shutdown_periods_r),
    .res              (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_lamp_on          = out_res_r.lamp_on;
  assign out_relay_on         = out_res_r.relay_on;
  assign out_shutdown_request = out_res_r.shutdown_request;
  assign out_mode_now         = out_res_r.mode_now;

  `PBSS_ASSERT_NEXT(a_adv_fills_out, clk, rst_n, adv, out_valid_r)
  `PBSS_ASSERT_SAME(a_no_overrun, clk, rst_n, in_valid && in_ready, !s1_valid_r || adv)
  `PBSS_ASSERT_SAME(a_req_matches_mode, clk, rst_n, out_valid_r,
    out_res_r.shutdown_request == (out_res_r.mode_now == pbss_pkg::MODE_SHUT))
  `PBSS_ASSERT_SAME(a_mode_legal, clk, rst_n, out_valid_r,
    out_res_r.mode_now == pbss_pkg::MODE_ON || out_res_r.mode_now == pbss_pkg::MODE_SHUT ||
    out_res_r.mode_now == pbss_pkg::MODE_OFF)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [pbss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN = 10;

  class shutdown_scoreboard;
    logic [pbss_pkg::CFG_W-1:0] debounce_lim;
    logic [pbss_pkg::CFG_W-1:0] blink_lim;
    logic [pbss_pkg::CFG_W-1:0] period_lim;
    pbss_pkg::mode_t mode;
    logic [7:0] press_cnt;
    logic [7:0] tick_cnt;
    logic [7:0] period_cnt;
    logic blink_phase;
    pbss_pkg::pbss_res_t result_q[$];
    int mismatches;

    function new();
      debounce_lim = pbss_pkg::DEBOUNCE_TICKS_RST;
      blink_lim = pbss_pkg::BLINK_TICKS_RST;
      period_lim = pbss_pkg::SHUTDOWN_PERIODS_RST;
      mode = pbss_pkg::MODE_ON;
      press_cnt = 8'd0;
      tick_cnt = 8'd0;
      period_cnt = 8'd0;
      blink_phase = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [pbss_pkg::CFG_IDX_W-1:0] idx,
                            logic [pbss_pkg::CFG_W-1:0] val);
      case (idx)
        pbss_pkg::CFG_DEBOUNCE_TICKS: debounce_lim = val;
        pbss_pkg::CFG_BLINK_TICKS: blink_lim = val;
        pbss_pkg::CFG_SHUTDOWN_PERIODS: period_lim = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] sat_inc(logic [7:0] v);
      return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function bit press_qualified(logic down);
      press_cnt = down ? sat_inc(press_cnt) : 8'd0;
      if (press_cnt >= debounce_lim) begin
        press_cnt = 8'd0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic down);
      pbss_pkg::pbss_res_t res;
      case (mode)
        pbss_pkg::MODE_ON: begin
          res.lamp_on = 1'b1;
          res.relay_on = 1'b1;
          if (press_qualified(down)) begin
            tick_cnt = 8'd0;
            period_cnt = 8'd0;
            mode = pbss_pkg::MODE_SHUT;
          end
        end
        pbss_pkg::MODE_SHUT: begin
          tick_cnt = sat_inc(tick_cnt);
          res.lamp_on = blink_phase;
          res.relay_on = 1'b1;
          if (period_cnt >= period_lim) mode = pbss_pkg::MODE_OFF;
          if (press_qualified(down)) begin
            period_cnt = 8'd0;
            mode = pbss_pkg::MODE_ON;
          end
        end
        default: begin
          res.lamp_on = 1'b0;
          res.relay_on = 1'b0;
          if (press_qualified(down)) mode = pbss_pkg::MODE_ON;
        end
      endcase
      res.shutdown_request = (mode == pbss_pkg::MODE_SHUT);
      res.mode_now = mode;
      if (tick_cnt >= blink_lim) begin
        tick_cnt = 8'd0;
        blink_phase = ~blink_phase;
        period_cnt = sat_inc(period_cnt);
      end
      result_q.push_back(res);
    endfunction

    function void check_result(pbss_pkg::pbss_res_t got);
      pbss_pkg::pbss_res_t want;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result item: lamp %0b relay %0b req %0b mode %0d",
                   got.lamp_on, got.relay_on, got.shutdown_request, got.mode_now);
        return;
      end
      want = result_q.pop_front();
      if (got.lamp_on !== want.lamp_on || got.relay_on !== want.relay_on ||
          got.shutdown_request !== want.shutdown_request ||
          got.mode_now !== want.mode_now) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"result mismatch at %0t: expected lamp %0b relay %0b req %0b mode %0d,",
                    " got lamp %0b relay %0b req %0b mode %0d"},
                   $realtime, want.lamp_on, want.relay_on, want.shutdown_request,
                   want.mode_now, got.lamp_on, got.relay_on, got.shutdown_request,
                   got.mode_now);
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_button_down = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_lamp_on;
  logic out_relay_on;
  logic out_shutdown_request;
  logic [1:0] out_mode_now;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pbss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pbss_pkg::CFG_W-1:0] cfg_data = '0;

  shutdown_scoreboard sb = new();
  bit calm = 1'b0;
  int ready_hold = 0;
  int items_sent = 0;
  int cur_debounce = 10;

  power_button_shutdown_sequencer_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_button_down(in_button_down),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_lamp_on(out_lamp_on),
    .out_relay_on(out_relay_on),
    .out_shutdown_request(out_shutdown_request),
    .out_mode_now(out_mode_now),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (calm || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [pbss_pkg::CFG_W-1:0] pick_reg();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd1;
    if (r == 2) return 8'd255;
    return 8'($urandom_range(1, 4));
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= 1'b0;
    end else if (calm || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      ready_hold = pick_gap();
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pbss_pkg::pbss_res_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_input(in_button_down);
      if (out_valid && out_ready) begin
        got.lamp_on = out_lamp_on;
        got.relay_on = out_relay_on;
        got.shutdown_request = out_shutdown_request;
        got.mode_now = pbss_pkg::mode_t'(out_mode_now);
        sb.check_result(got);
      end
    end
  end

  task automatic send_item(logic down);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_button_down <= down;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic button_run(logic down, int n);
    repeat (n) send_item(down);
  endtask

  task automatic write_reg(logic [pbss_pkg::CFG_IDX_W-1:0] idx,
                           logic [pbss_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [pbss_pkg::CFG_W-1:0] deb,
                            logic [pbss_pkg::CFG_W-1:0] blink,
                            logic [pbss_pkg::CFG_W-1:0] periods);
    write_reg(pbss_pkg::CFG_DEBOUNCE_TICKS, deb);
    write_reg(pbss_pkg::CFG_BLINK_TICKS, blink);
    write_reg(pbss_pkg::CFG_SHUTDOWN_PERIODS, periods);
    cur_debounce = int'(deb);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int target;
    int kind;
    int burst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: short press, release, qualified press, shutdown ticks
    button_run(1'b1, 2);
    button_run(1'b0, 1);
    button_run(1'b1, 10);
    button_run(1'b0, 3);

    // minimum settings: press out of shutdown, back in, time out to off, press on
    wait_idle();
    set_config(8'd1, 8'd1, 8'd1);
    button_run(1'b1, 2);
    button_run(1'b0, 3);
    button_run(1'b1, 1);

    // zero settings: every tick qualifies, even released
    wait_idle();
    set_config(8'd0, 8'd0, 8'd0);
    button_run(1'b0, 3);

    wait_idle();
    set_config(8'd255, 8'd255, 8'd255);
    write_reg(CFG_UNUSED, 8'hff);
    button_run(1'b1, 2);

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      set_config(pick_reg(), pick_reg(), pick_reg());
      if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, 8'($urandom));
      target = items_sent + 30;
      while (items_sent < target) begin
        kind = $urandom_range(0, 9);
        burst = (cur_debounce == 0) ? 1 : cur_debounce;
        if (burst > 12) burst = $urandom_range(1, 12);
        if (kind <= 6) begin
          button_run(1'b1, burst);
          button_run(1'b0, $urandom_range(1, 6));
        end else if (kind == 7) begin
          button_run(1'b0, $urandom_range(8, 25));
        end else if (kind == 8) begin
          button_run(1'b1, (burst > 1) ? $urandom_range(1, burst - 1) : 1);
          button_run(1'b0, 1);
        end else begin
          repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)));
        end
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
